// ----- rtl/stepper_trapezoid_ramp_macros.svh -----
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_macros
// assertion macros used by the stepper ramp top level
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_MACROS_SVH

`ifndef SYNTHESIS

`define STR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stepper ramp check failed");

`define STR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("stepper ramp forbidden condition");

`else

`define STR_ASSERT(lbl, prop)

`define STR_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ----- rtl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// types and constants of the stepper trapezoid ramp generator
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int LIMIT_W    = 24;
  localparam int CFGD_W     = 16;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int SPAN_W     = LIMIT_W + 1;
  localparam int PROD_W     = FRAC_W + 1 + SPAN_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int QUOT_W     = NUM_W - FRAC_SHIFT;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = '0;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = '0;
  localparam logic [CFGD_W-1:0]  MIN_DELAY_RST  = 16'd250;
  localparam logic [CFGD_W-1:0]  MAX_DELAY_RST  = 16'd2000;
  localparam logic [CFGD_W-1:0]  ACCEL_RST      = 16'd100;
  localparam logic [CFGD_W-1:0]  DELAY_INC_RST  = 16'd17;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_STOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_RUN  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_LOW_LIMIT   = 3'd0,
    REG_HIGH_LIMIT  = 3'd1,
    REG_MIN_DELAY   = 3'd2,
    REG_MAX_DELAY   = 3'd3,
    REG_ACCEL_STEPS = 3'd4,
    REG_DELAY_INC   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] low_limit;
    logic [LIMIT_W-1:0] high_limit;
    logic [CFGD_W-1:0]  min_delay;
    logic [CFGD_W-1:0]  max_delay;
    logic [CFGD_W-1:0]  accel_steps;
    logic [CFGD_W-1:0]  delay_increment;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic              run_reverse;
    logic [PROD_W-1:0] product;
  } item_t;

endpackage

// ----- rtl/stp_regs.sv -----
// ----------------------------------------------------------------------------
// stp_regs
// apb configuration registers of the stepper ramp generator
// ----------------------------------------------------------------------------
module stp_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [stp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output stp_pkg::cfg_t                  cfg_o
);
  import stp_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic write_en;

  assign idx      = reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign write_en = psel & penable & pwrite;
  assign pready   = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (write_en) begin
      unique case (idx)
        REG_LOW_LIMIT:   cfg_d.low_limit       = pwdata[LIMIT_W-1:0];
        REG_HIGH_LIMIT:  cfg_d.high_limit      = pwdata[LIMIT_W-1:0];
        REG_MIN_DELAY:   cfg_d.min_delay       = pwdata[CFGD_W-1:0];
        REG_MAX_DELAY:   cfg_d.max_delay       = pwdata[CFGD_W-1:0];
        REG_ACCEL_STEPS: cfg_d.accel_steps     = pwdata[CFGD_W-1:0];
        REG_DELAY_INC:   cfg_d.delay_increment = pwdata[CFGD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW_LIMIT:
        prdata = {{(CFG_DATA_W-LIMIT_W){cfg_q.low_limit[LIMIT_W-1]}}, cfg_q.low_limit};
      REG_HIGH_LIMIT:
        prdata = {{(CFG_DATA_W-LIMIT_W){cfg_q.high_limit[LIMIT_W-1]}}, cfg_q.high_limit};
      REG_MIN_DELAY:   prdata = {{(CFG_DATA_W-CFGD_W){1'b0}}, cfg_q.min_delay};
      REG_MAX_DELAY:   prdata = {{(CFG_DATA_W-CFGD_W){1'b0}}, cfg_q.max_delay};
      REG_ACCEL_STEPS: prdata = {{(CFG_DATA_W-CFGD_W){1'b0}}, cfg_q.accel_steps};
      REG_DELAY_INC:   prdata = {{(CFG_DATA_W-CFGD_W){1'b0}}, cfg_q.delay_increment};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit       <= LOW_LIMIT_RST;
      cfg_q.high_limit      <= HIGH_LIMIT_RST;
      cfg_q.min_delay       <= MIN_DELAY_RST;
      cfg_q.max_delay       <= MAX_DELAY_RST;
      cfg_q.accel_steps     <= ACCEL_RST;
      cfg_q.delay_increment <= DELAY_INC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/stp_front.sv -----
// ----------------------------------------------------------------------------
// stp_front
// input register stage, forms the span product of a move target
// ----------------------------------------------------------------------------
module stp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_fire_i,
  input  logic                       adv_i,
  input  logic [1:0]                 cmd_i,
  input  logic [stp_pkg::FRAC_W-1:0] target_fraction_i,
  input  logic                       run_reverse_i,
  input  stp_pkg::cfg_t              cfg_i,
  output logic                       valid_o,
  output stp_pkg::item_t             item_o
);
  import stp_pkg::*;

  logic signed [SPAN_W-1:0] span;
  logic signed [PROD_W-1:0] prod;
  logic  valid_q, valid_d;
  item_t item_q, item_d;

  // span of the limits, then fraction times span
  assign span = $signed({cfg_i.high_limit[LIMIT_W-1], cfg_i.high_limit})
              - $signed({cfg_i.low_limit[LIMIT_W-1], cfg_i.low_limit});
  assign prod = $signed({1'b0, target_fraction_i}) * span;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_fire_i) begin
      valid_d             = 1'b1;
      item_d.cmd          = cmd_e'(cmd_i);
      item_d.run_reverse  = run_reverse_i;
      item_d.product      = prod;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/stp_core.sv -----
// ----------------------------------------------------------------------------
// stp_core
// motion state, delay ramp, step decision and result register
// ----------------------------------------------------------------------------
module stp_core #(
  parameter int P = 24,
  parameter int D = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  stp_pkg::item_t item_i,
  input  stp_pkg::cfg_t  cfg_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           step_pulse_o,
  output logic           step_forward_o,
  output logic [P-1:0]   position_o,
  output logic [1:0]     mode_o
);
  import stp_pkg::*;

  localparam int CW = (D > CFGD_W ? D : CFGD_W) + 1;
  localparam int TW = (P + 1 > CFGD_W ? P + 1 : CFGD_W) + 1;
  localparam int QW = (QUOT_W > P ? QUOT_W : P) + 1;
  localparam logic [D-1:0] DMAX = {D{1'b1}};
  localparam logic [P-1:0] PMAX = {1'b0, {(P-1){1'b1}}};
  localparam logic [P-1:0] PMIN = {1'b1, {(P-1){1'b0}}};

  logic [P-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic [D-1:0] delay_q, delay_d, elapsed_q, elapsed_d;
  mode_e        mode_q, mode_d;
  logic         runneg_q, runneg_d;
  logic         valid_q, valid_d, pulse_q, pulse_d, fwd_q, fwd_d;

  logic signed [NUM_W-1:0]  low_ext, prod_ext, num;
  logic signed [QUOT_W-1:0] quot;
  logic signed [QW-1:0]     q_ext, pmax_ext, pmin_ext;
  logic [P-1:0]             tgt_sat;

  logic [CW-1:0] delay_ext, min_ext, inc_ext, max_ext, inc_sum;
  logic [D-1:0]  max_d, delay_dn, delay_up, elapsed_inc;
  logic          above_min, step_due;

  logic signed [P:0] diff;
  logic [P:0]        togo;
  logic              togo_lt;

  // move target, rounded toward zero and saturated
  assign low_ext  = {{(NUM_W-LIMIT_W-FRAC_SHIFT){cfg_i.low_limit[LIMIT_W-1]}},
                     cfg_i.low_limit, {FRAC_SHIFT{1'b0}}};
  assign prod_ext = {item_i.product[PROD_W-1], item_i.product};
  assign num      = low_ext + prod_ext;
  assign quot     = num[NUM_W-1:FRAC_SHIFT]
                  + QUOT_W'(num[NUM_W-1] && (num[FRAC_SHIFT-1:0] != '0));
  assign q_ext    = {{(QW-QUOT_W){quot[QUOT_W-1]}}, quot};
  assign pmax_ext = {{(QW-P){1'b0}}, PMAX};
  assign pmin_ext = {{(QW-P){1'b1}}, PMIN};

  always_comb begin
    if (q_ext > pmax_ext) begin
      tgt_sat = PMAX;
    end else if (q_ext < pmin_ext) begin
      tgt_sat = PMIN;
    end else begin
      tgt_sat = q_ext[P-1:0];
    end
  end

  // delay ramp
  assign max_ext   = CW'(cfg_i.max_delay);
  assign max_d     = max_ext[D-1:0];
  assign delay_ext = CW'(delay_q);
  assign min_ext   = CW'(cfg_i.min_delay);
  assign inc_ext   = CW'(cfg_i.delay_increment);
  assign inc_sum   = delay_ext + inc_ext;
  assign above_min = delay_ext > min_ext;
  assign delay_dn  = (delay_ext > inc_ext) ? D'(delay_ext - inc_ext) : '0;
  assign delay_up  = (inc_sum > CW'(DMAX)) ? DMAX : inc_sum[D-1:0];

  assign elapsed_inc = (elapsed_q != DMAX) ? elapsed_q + D'(1) : elapsed_q;
  assign step_due    = (mode_q != MODE_IDLE) && (elapsed_inc >= delay_q);

  assign diff    = $signed({tgt_q[P-1], tgt_q}) - $signed({cur_q[P-1], cur_q});
  assign togo    = diff[P] ? (P+1)'(-diff) : diff;
  assign togo_lt = TW'(togo) < TW'(cfg_i.accel_steps);

  always_comb begin
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    delay_d   = delay_q;
    elapsed_d = elapsed_q;
    mode_d    = mode_q;
    runneg_d  = runneg_q;
    pulse_d   = 1'b0;
    fwd_d     = 1'b0;
    unique case (item_i.cmd)
      CMD_MOVE: begin
        tgt_d   = tgt_sat;
        delay_d = max_d;
        mode_d  = MODE_MOVE;
      end
      CMD_RUN: begin
        delay_d  = max_d;
        runneg_d = item_i.run_reverse;
        mode_d   = MODE_RUN;
      end
      CMD_STOP: begin
        mode_d = MODE_IDLE;
      end
      CMD_TICK: begin
        elapsed_d = elapsed_inc;
        if (step_due) begin
          elapsed_d = '0;
          if (mode_q == MODE_RUN) begin
            if (above_min) delay_d = delay_dn;
            if (runneg_q) begin
              if (cur_q != PMIN) begin
                cur_d   = cur_q - P'(1);
                pulse_d = 1'b1;
              end
            end else if (cur_q != PMAX) begin
              cur_d   = cur_q + P'(1);
              pulse_d = 1'b1;
              fwd_d   = 1'b1;
            end
          end else begin
            if (togo_lt) begin
              delay_d = delay_up;
            end else if (above_min) begin
              delay_d = delay_dn;
            end
            if (diff > 0) begin
              if (cur_q != PMAX) begin
                cur_d   = cur_q + P'(1);
                pulse_d = 1'b1;
                fwd_d   = 1'b1;
              end
            end else if (diff < 0) begin
              if (cur_q != PMIN) begin
                cur_d   = cur_q - P'(1);
                pulse_d = 1'b1;
              end
            end
            if (togo == '0) mode_d = MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (adv_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      tgt_q     <= '0;
      elapsed_q <= '0;
      mode_q    <= MODE_IDLE;
      runneg_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (adv_i) begin
        cur_q     <= cur_d;
        tgt_q     <= tgt_d;
        elapsed_q <= elapsed_d;
        mode_q    <= mode_d;
        runneg_q  <= runneg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      delay_q <= delay_d;
      pulse_q <= pulse_d;
      fwd_q   <= fwd_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign step_pulse_o   = pulse_q;
  assign step_forward_o = fwd_q;
  assign position_o     = cur_q;
  assign mode_o         = mode_q;

endmodule

// ----- rtl/stepper_trapezoid_ramp.sv -----
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// stepper motor step generator with a linear trapezoidal delay ramp
//
//   port     handshake                        beat
//   in       in_valid_i / in_ready_o          cmd, target_fraction, run_reverse
//   out      out_valid_o / out_ready_i        step_pulse, step_forward, position, mode
//   cfg      psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// one beat per cycle each way while not stalled; input register, then result register
// the span multiply sits before the input register, the target add and the
// step decision before the result register
// reset clears position, target, elapsed ticks, mode and direction
// a stalled result holds the input stage, which then holds in_ready_o low
// ----------------------------------------------------------------------------
`include "stepper_trapezoid_ramp_macros.svh"

module stepper_trapezoid_ramp #(
  parameter int POSITION_BITS = 24,
  parameter int DELAY_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [stp_pkg::FRAC_W-1:0]     target_fraction_i,
  input  logic                           run_reverse_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           step_pulse_o,
  output logic                           step_forward_o,
  output logic [POSITION_BITS-1:0]       position_o,
  output logic [1:0]                     mode_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [stp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [stp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import stp_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  s1_valid, s1_fire, in_fire;

  assign s1_fire    = s1_valid && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  stp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  stp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_fire_i         (in_fire),
    .adv_i             (s1_fire),
    .cmd_i             (cmd_i),
    .target_fraction_i (target_fraction_i),
    .run_reverse_i     (run_reverse_i),
    .cfg_i             (cfg),
    .valid_o           (s1_valid),
    .item_o            (item)
  );

  stp_core #(
    .P (POSITION_BITS),
    .D (DELAY_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (s1_fire),
    .item_i         (item),
    .cfg_i          (cfg),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .step_pulse_o   (step_pulse_o),
    .step_forward_o (step_forward_o),
    .position_o     (position_o),
    .mode_o         (mode_o)
  );

  `STR_ASSERT_NEVER(a_fwd_without_pulse, out_valid_o && step_forward_o && !step_pulse_o)
  `STR_ASSERT(a_pulse_in_motion, out_valid_o && step_pulse_o |-> mode_o != MODE_IDLE)
  `STR_ASSERT(a_stall_cause, !in_ready_o |-> s1_valid && out_valid_o && !out_ready_i)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stepper trapezoid ramp generator
// a directed table and random command phases under several register
// settings drive the command port with random gaps and result stalls;
// every result beat is compared field by field with a pinned beat from the
// table or with a behavioral model of the ramp kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
  import stp_pkg::*;

  localparam int     POS_W         = 24;
  localparam int     DLY_W         = 16;
  localparam longint POS_HI        = (64'sd1 << (POS_W - 1)) - 1;
  localparam longint POS_LO        = -POS_HI - 1;
  localparam longint DLY_SAT       = (64'sd1 << DLY_W) - 1;
  localparam int     QUIET_LIMIT   = 2000;
  localparam int     MAX_REPORTS   = 10;
  localparam int     RANDOM_PHASES = 11;
  localparam int     PHASE_ITEMS   = 40;

  typedef struct packed {
    logic             pulse;
    logic             fwd;
    logic [POS_W-1:0] pos;
    mode_e            mode;
  } step_beat_t;

  typedef struct {
    bit         typed;
    step_beat_t beat;
  } pin_t;

  typedef struct {
    bit                is_reg;
    reg_e              rsel;
    logic [31:0]       wval;
    cmd_e              cmd;
    logic [FRAC_W-1:0] frac;
    logic              rev;
    pin_t              pin;
  } plan_row_t;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            cmd_i             = CMD_TICK;
  logic [FRAC_W-1:0]     target_fraction_i = '0;
  logic                  run_reverse_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i       = 1'b0;
  logic                  step_pulse_o;
  logic                  step_forward_o;
  logic [POS_W-1:0]      position_o;
  logic [1:0]            mode_o;
  logic                  psel              = 1'b0;
  logic                  penable           = 1'b0;
  logic                  pwrite            = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr             = '0;
  logic [CFG_DATA_W-1:0] pwdata            = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // ramp model state and register copies
  longint lim_lo      = 0;
  longint lim_hi      = 0;
  longint dly_min     = 250;
  longint dly_max     = 2000;
  longint accel_len   = 100;
  longint dly_inc     = 17;
  longint pos_now     = 0;
  longint pos_goal    = 0;
  longint delay_cur   = 0;
  longint ticks_since = 0;
  mode_e  motion      = MODE_IDLE;
  logic   run_rev     = 1'b0;

  step_beat_t expected_steps_q[$];
  pin_t       pins_q[$];
  pin_t       no_pin;
  bit         steady       = 1'b0;
  int         bad_beats    = 0;
  int         quiet_cycles = 0;

  stepper_trapezoid_ramp dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .target_fraction_i (target_fraction_i),
    .run_reverse_i     (run_reverse_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .step_pulse_o      (step_pulse_o),
    .step_forward_o    (step_forward_o),
    .position_o        (position_o),
    .mode_o            (mode_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint delay_less(longint d);
    return (d > dly_inc) ? d - dly_inc : 0;
  endfunction

  function automatic step_beat_t ramp_step_predict(cmd_e c, logic [FRAC_W-1:0] f, logic r);
    step_beat_t b;
    longint q;
    longint delta;
    longint togo;
    longint nxt;
    b.pulse = 1'b0;
    b.fwd   = 1'b0;
    case (c)
      CMD_MOVE: begin
        q = (lim_lo * 65536 + longint'(f) * (lim_hi - lim_lo)) / 65536;
        pos_goal  = (q > POS_HI) ? POS_HI : ((q < POS_LO) ? POS_LO : q);
        delay_cur = dly_max;
        motion    = MODE_MOVE;
      end
      CMD_RUN: begin
        delay_cur = dly_max;
        run_rev   = r;
        motion    = MODE_RUN;
      end
      CMD_STOP: motion = MODE_IDLE;
      default: begin
        if (ticks_since < DLY_SAT) ticks_since++;
        if (motion != MODE_IDLE && ticks_since >= delay_cur) begin
          if (motion == MODE_RUN) begin
            if (delay_cur > dly_min) delay_cur = delay_less(delay_cur);
            nxt = run_rev ? pos_now - 1 : pos_now + 1;
            if (nxt <= POS_HI && nxt >= POS_LO) begin
              pos_now = nxt;
              b.pulse = 1'b1;
              b.fwd   = ~run_rev;
            end
          end else begin
            delta = pos_goal - pos_now;
            togo  = (delta < 0) ? -delta : delta;
            if (togo < accel_len) begin
              delay_cur = delay_cur + dly_inc;
              if (delay_cur > DLY_SAT) delay_cur = DLY_SAT;
            end else if (delay_cur > dly_min) begin
              delay_cur = delay_less(delay_cur);
            end
            if (delta != 0) begin
              nxt = (delta > 0) ? pos_now + 1 : pos_now - 1;
              if (nxt <= POS_HI && nxt >= POS_LO) begin
                pos_now = nxt;
                b.pulse = 1'b1;
                b.fwd   = (delta > 0);
              end
            end
            if (togo == 0) motion = MODE_IDLE;
          end
          ticks_since = 0;
        end
      end
    endcase
    b.pos  = pos_now[POS_W-1:0];
    b.mode = motion;
    return b;
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    if ($urandom_range(0, 9) == 0) return FRAC_W'($urandom_range(0, 131071));
    return FRAC_W'($urandom_range(0, 65536));
  endfunction

  function automatic plan_row_t free_row(cmd_e c, logic [FRAC_W-1:0] f, logic r);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.rsel   = REG_LOW_LIMIT;
    row.wval   = '0;
    row.cmd    = c;
    row.frac   = f;
    row.rev    = r;
    row.pin    = no_pin;
    return row;
  endfunction

  // no step, still at the origin, mode as given
  function automatic plan_row_t pinned_row(cmd_e c, logic [FRAC_W-1:0] f, logic r, mode_e m);
    plan_row_t row;
    row                = free_row(c, f, r);
    row.pin.typed      = 1'b1;
    row.pin.beat.pulse = 1'b0;
    row.pin.beat.fwd   = 1'b0;
    row.pin.beat.pos   = '0;
    row.pin.beat.mode  = m;
    return row;
  endfunction

  function automatic plan_row_t reg_row(reg_e idx, logic [31:0] v);
    plan_row_t row;
    row        = free_row(CMD_TICK, '0, 1'b0);
    row.is_reg = 1'b1;
    row.rsel   = idx;
    row.wval   = v;
    return row;
  endfunction

  task automatic send_cmd(cmd_e c, logic [FRAC_W-1:0] f, logic r, pin_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pins_q.push_back(p);
    in_valid_i        <= 1'b1;
    cmd_i             <= c;
    target_fraction_i <= f;
    run_reverse_i     <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOW_LIMIT:   lim_lo    = longint'($signed(v[POS_W-1:0]));
      REG_HIGH_LIMIT:  lim_hi    = longint'($signed(v[POS_W-1:0]));
      REG_MIN_DELAY:   dly_min   = longint'(v[DLY_W-1:0]);
      REG_MAX_DELAY:   dly_max   = longint'(v[DLY_W-1:0]);
      REG_ACCEL_STEPS: accel_len = longint'(v[DLY_W-1:0]);
      default:         dly_inc   = longint'(v[DLY_W-1:0]);
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_steps_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // command beats accepted: advance the ramp model
  always @(posedge clk_i) begin : accept_cmd
    step_beat_t b;
    pin_t       p;
    if (rst_ni && in_valid_i && in_ready_o) begin
      b = ramp_step_predict(cmd_e'(cmd_i), target_fraction_i, run_reverse_i);
      p = pins_q.pop_front();
      expected_steps_q.push_back(p.typed ? p.beat : b);
    end
  end

  always @(posedge clk_i) begin : check_step
    step_beat_t want;
    step_beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.pulse = step_pulse_o;
      got.fwd   = step_forward_o;
      got.pos   = position_o;
      got.mode  = mode_e'(mode_o);
      if (expected_steps_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS)
          $display("unexpected result beat: pulse=%0b fwd=%0b pos=%0d mode=%0d",
                   got.pulse, got.fwd, $signed(got.pos), got.mode);
      end else begin
        want = expected_steps_q.pop_front();
        if (got.pulse !== want.pulse || got.fwd !== want.fwd ||
            got.pos !== want.pos || got.mode !== want.mode) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("step beat mismatch: want pulse=%0b fwd=%0b pos=%0d mode=%0d, %s",
                     want.pulse, want.fwd, $signed(want.pos), want.mode,
                     $sformatf("got pulse=%0b fwd=%0b pos=%0d mode=%0d",
                               got.pulse, got.fwd, $signed(got.pos), got.mode));
        end
      end
    end
  end

  // result side stalls
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    int        items;
    int        span;
    int        pick;
    longint    lo;
    longint    hi;
    longint    dmin;
    cmd_e      c;

    // directed table
    plan.push_back(pinned_row(CMD_TICK, '0, 1'b0, MODE_IDLE));
    plan.push_back(pinned_row(CMD_RUN, '0, 1'b0, MODE_RUN));
    plan.push_back(pinned_row(CMD_TICK, '0, 1'b0, MODE_RUN));
    plan.push_back(pinned_row(CMD_STOP, '0, 1'b0, MODE_IDLE));
    plan.push_back(pinned_row(CMD_MOVE, 17'h1FFFF, 1'b1, MODE_MOVE));
    plan.push_back(pinned_row(CMD_MOVE, 17'h10000, 1'b0, MODE_MOVE));
    plan.push_back(pinned_row(CMD_STOP, '0, 1'b0, MODE_IDLE));
    plan.push_back(pinned_row(CMD_RUN, '0, 1'b1, MODE_RUN));
    plan.push_back(pinned_row(CMD_STOP, '0, 1'b0, MODE_IDLE));
    plan.push_back(reg_row(REG_HIGH_LIMIT, 12));
    plan.push_back(reg_row(REG_MIN_DELAY, 1));
    plan.push_back(reg_row(REG_MAX_DELAY, 3));
    plan.push_back(reg_row(REG_ACCEL_STEPS, 4));
    plan.push_back(reg_row(REG_DELAY_INC, 1));
    plan.push_back(free_row(CMD_MOVE, 17'h10000, 1'b0));
    repeat (7) plan.push_back(free_row(CMD_TICK, 17'h0AAAA, 1'b1));
    plan.push_back(free_row(CMD_RUN, 17'h15555, 1'b1));
    repeat (3) plan.push_back(free_row(CMD_TICK, '0, 1'b0));
    plan.push_back(free_row(CMD_STOP, '0, 1'b0));
    plan.push_back(reg_row(REG_LOW_LIMIT, 32'hFF80_0000));
    plan.push_back(reg_row(REG_HIGH_LIMIT, 32'h007F_FFFF));
    plan.push_back(free_row(CMD_MOVE, 17'h1FFFF, 1'b0));
    plan.push_back(free_row(CMD_MOVE, '0, 1'b1));
    plan.push_back(free_row(CMD_STOP, '0, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].rsel, plan[i].wval);
      end else begin
        send_cmd(plan[i].cmd, plan[i].frac, plan[i].rev, plan[i].pin);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      pick = (ph < 2) ? ph : $urandom_range(2, 9);
      if (pick == 0) begin
        write_reg(REG_LOW_LIMIT, 32'hFF80_0000);
        write_reg(REG_HIGH_LIMIT, 32'h007F_FFFF);
        write_reg(REG_MIN_DELAY, 32'h0000_FFFF);
        write_reg(REG_MAX_DELAY, 32'h0000_FFFF);
        write_reg(REG_ACCEL_STEPS, 32'h0000_FFFF);
        write_reg(REG_DELAY_INC, 32'h0000_FFFF);
      end else if (pick == 1) begin
        write_reg(REG_LOW_LIMIT, 32'h007F_FFFF);
        write_reg(REG_HIGH_LIMIT, 32'hFF80_0000);
        write_reg(REG_MIN_DELAY, 1);
        write_reg(REG_MAX_DELAY, 1);
        write_reg(REG_ACCEL_STEPS, 1);
        write_reg(REG_DELAY_INC, 0);
      end else if (pick == 2) begin
        write_reg(REG_LOW_LIMIT, $urandom_range(0, 1) ? 32'hFF80_0000 : 32'h007F_FFFF);
        write_reg(REG_HIGH_LIMIT, $urandom_range(0, 1) ? 32'hFF80_0000 : 32'h007F_FFFF);
        write_reg(REG_MIN_DELAY, $urandom_range(0, 1) ? 1 : 32'h0000_FFFF);
        write_reg(REG_MAX_DELAY, $urandom_range(0, 1) ? 1 : 32'h0000_FFFF);
        write_reg(REG_ACCEL_STEPS, $urandom_range(0, 1) ? 1 : 32'h0000_FFFF);
        write_reg(REG_DELAY_INC, $urandom_range(0, 1) ? 0 : 32'h0000_FFFF);
      end else begin
        // short spans near the current position so moves can finish
        lo   = pos_now + longint'($urandom_range(0, 40)) - 20;
        hi   = lo + longint'($urandom_range(0, 40)) - 20;
        dmin = longint'($urandom_range(1, 3));
        write_reg(REG_LOW_LIMIT, 32'(lo));
        write_reg(REG_HIGH_LIMIT, 32'(hi));
        write_reg(REG_MIN_DELAY, 32'(dmin));
        write_reg(REG_MAX_DELAY, 32'(dmin + longint'($urandom_range(0, 10))));
        write_reg(REG_ACCEL_STEPS, $urandom_range(1, 6));
        write_reg(REG_DELAY_INC, $urandom_range(0, 3));
      end
      steady = ($urandom_range(0, 3) == 0);
      items  = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          c = CMD_MOVE;
        end else if (pick < 80) begin
          c = CMD_RUN;
        end else if (pick < 90) begin
          c = CMD_STOP;
        end else begin
          c = CMD_TICK;
        end
        send_cmd(c, rand_frac(), 1'($urandom_range(0, 1)), no_pin);
        span = $urandom_range(3, 30);
        repeat (span) send_cmd(CMD_TICK, rand_frac(), 1'($urandom_range(0, 1)), no_pin);
        items += span + 1;
      end
    end

    steady = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (bad_beats == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
